>>> hw/rtl/sha_pkg.sv
// ----------------------------------------------------------------------------
// sha_pkg: shared types, constants and functions of the SHA-256 hasher
// Round constants, initial hash words and the sigma functions of the
// compression round.
// ----------------------------------------------------------------------------
package sha_pkg;

  typedef logic [31:0]      word_t;
  typedef word_t [7:0]      vars_t;   // index 0 is a, index 7 is h
  typedef word_t [15:0]     sched_t;  // index 0 is the oldest word

  localparam int unsigned NUM_ROUNDS = 64;
  localparam logic [7:0]  PAD_BYTE   = 8'h80;

  localparam vars_t INIT_H = {
    32'h5be0cd19, 32'h1f83d9ab, 32'h9b05688c, 32'h510e527f,
    32'ha54ff53a, 32'h3c6ef372, 32'hbb67ae85, 32'h6a09e667
  };

  localparam word_t ROUND_K [NUM_ROUNDS] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5,
    32'h3956c25b, 32'h59f111f1, 32'h923f82a4, 32'hab1c5ed5,
    32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174,
    32'he49b69c1, 32'hefbe4786, 32'h0fc19dc6, 32'h240ca1cc,
    32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7,
    32'hc6e00bf3, 32'hd5a79147, 32'h06ca6351, 32'h14292967,
    32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85,
    32'ha2bfe8a1, 32'ha81a664b, 32'hc24b8b70, 32'hc76c51a3,
    32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5,
    32'h391c0cb3, 32'h4ed8aa4a, 32'h5b9cca4f, 32'h682e6ff3,
    32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2
  };

  function automatic word_t big_sig0(word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sig1(word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

  function automatic word_t small_sig0(word_t x);
    return {x[6:0], x[31:7]} ^ {x[17:0], x[31:18]} ^ {3'b000, x[31:3]};
  endfunction

  function automatic word_t small_sig1(word_t x);
    return {x[16:0], x[31:17]} ^ {x[18:0], x[31:19]} ^ {10'd0, x[31:10]};
  endfunction

endpackage

>>> hw/rtl/sha_if.sv
// ----------------------------------------------------------------------------
// sha_if: request channels of the SHA-256 hasher
// Byte input channel and digest word output channel, valid/ready handshake.
// ----------------------------------------------------------------------------
interface sha_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_present;
  logic       end_of_message;

  modport source (output valid, data_byte, byte_present, end_of_message, input ready);
  modport sink   (input valid, data_byte, byte_present, end_of_message, output ready);
endinterface

interface sha_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;

  modport source (output valid, digest_word, word_index, last_word, input ready);
  modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

>>> hw/rtl/sha_round.sv
// ----------------------------------------------------------------------------
// sha_round: one SHA-256 compression round
// Updates the working variables from the current schedule word and computes
// the schedule word sixteen rounds ahead.
// ----------------------------------------------------------------------------
module sha_round (
  input  sha_pkg::vars_t  vars_i,
  input  sha_pkg::sched_t sched_i,
  input  sha_pkg::word_t  k_i,
  output sha_pkg::vars_t  vars_o,
  output sha_pkg::word_t  w_new_o
);
  import sha_pkg::*;

  word_t t1;
  word_t t2;
  word_t ch;
  word_t maj;

  assign ch  = (vars_i[4] & vars_i[5]) ^ (~vars_i[4] & vars_i[6]);
  assign maj = (vars_i[0] & vars_i[1]) ^ (vars_i[0] & vars_i[2]) ^ (vars_i[1] & vars_i[2]);
  assign t1  = vars_i[7] + big_sig1(vars_i[4]) + ch + k_i + sched_i[0];
  assign t2  = big_sig0(vars_i[0]) + maj;

  always_comb begin
    vars_o[7] = vars_i[6];
    vars_o[6] = vars_i[5];
    vars_o[5] = vars_i[4];
    vars_o[4] = vars_i[3] + t1;
    vars_o[3] = vars_i[2];
    vars_o[2] = vars_i[1];
    vars_o[1] = vars_i[0];
    vars_o[0] = t1 + t2;
  end

  // W[i+16] from the window W[i] .. W[i+15]
  assign w_new_o = small_sig1(sched_i[14]) + sched_i[9] + small_sig0(sched_i[1]) + sched_i[0];

endmodule

>>> hw/rtl/sha256_byte_stream_hasher_core.sv
// ----------------------------------------------------------------------------
// sha256_byte_stream_hasher_core: SHA-256 over a byte stream
// Packs bytes into 64-byte blocks, pads at end of message and emits the
// eight digest words.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one message byte per request (byte_present) and an
//         end_of_message flag; a request with neither flag set is a no-op.
//   out_o carries the digest, eight requests, word_index 0 first, last_word
//         on word 7.
// Sequence:
//   A byte that does not complete a block leaves in_i ready; the next byte can
//   follow immediately. The 64th byte of a block starts a compression: a
//   load state, 64 rounds on the single shared round unit and the chain add,
//   and in_i is not ready until the compression is done.
//   End of message: a pad state, then one compression, or two when 56 or
//   more bytes sit in the last block (with a length state between them), then
//   the eight digest words, one per cycle while out_o is ready.
// Reset: chain value, block buffer and counters return to the initial
//   state; the same happens after the last digest word is taken.
// Stall: while out_o is not ready the current word holds and no new input
//   is accepted.
// ----------------------------------------------------------------------------
module sha256_byte_stream_hasher_core (
  input  logic      clk_i,
  input  logic      rst_ni,
  sha_in_if.sink    in_i,
  sha_out_if.source out_o
);
  import sha_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_PAD   = 3'd1;
  localparam logic [2:0] S_LEN   = 3'd2;
  localparam logic [2:0] S_LOAD  = 3'd3;
  localparam logic [2:0] S_ROUND = 3'd4;
  localparam logic [2:0] S_ADD   = 3'd5;
  localparam logic [2:0] S_OUT   = 3'd6;

  // where to go once a compression is done
  localparam logic [1:0] RET_IDLE = 2'd0;
  localparam logic [1:0] RET_PAD  = 2'd1;
  localparam logic [1:0] RET_LEN  = 2'd2;
  localparam logic [1:0] RET_OUT  = 2'd3;

  localparam logic [5:0] LAST_BYTE  = 6'd63;
  localparam logic [5:0] LAST_ROUND = 6'(NUM_ROUNDS - 1);
  localparam logic [2:0] LAST_IDX   = 3'd7;

  logic [2:0]  state_q, state_d;
  logic [1:0]  ret_q, ret_d;
  logic [5:0]  cnt_q, cnt_d;
  logic [60:0] total_q, total_d;
  logic [5:0]  rnd_q, rnd_d;
  logic [2:0]  oidx_q, oidx_d;
  vars_t       chain_q, chain_d;
  sched_t      blk_q, blk_d;
  vars_t       vars_q, vars_d;
  sched_t      sched_q, sched_d;

  vars_t       rnd_vars;
  word_t       w_new;
  logic [63:0] bit_len;
  logic        in_acc;
  logic        out_acc;

  sha_round u_round (
    .vars_i  (vars_q),
    .sched_i (sched_q),
    .k_i     (ROUND_K[rnd_q]),
    .vars_o  (rnd_vars),
    .w_new_o (w_new)
  );

  assign bit_len = {total_q, 3'b000};

  assign in_i.ready        = (state_q == S_IDLE);
  assign out_o.valid       = (state_q == S_OUT);
  assign out_o.digest_word = chain_q[oidx_q];
  assign out_o.word_index  = oidx_q;
  assign out_o.last_word   = (oidx_q == LAST_IDX);

  assign in_acc  = in_i.valid && in_i.ready;
  assign out_acc = out_o.valid && out_o.ready;

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    cnt_d   = cnt_q;
    total_d = total_q;
    rnd_d   = rnd_q;
    oidx_d  = oidx_q;
    chain_d = chain_q;
    blk_d   = blk_q;
    vars_d  = vars_q;
    sched_d = sched_q;

    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          if (in_i.byte_present) begin
            blk_d[cnt_q[5:2]][{~cnt_q[1:0], 3'b000} +: 8] = in_i.data_byte;
            cnt_d   = cnt_q + 6'd1;
            total_d = total_q + 61'd1;
          end
          if (in_i.byte_present && cnt_q == LAST_BYTE) begin
            state_d = S_LOAD;
            ret_d   = in_i.end_of_message ? RET_PAD : RET_IDLE;
          end else if (in_i.end_of_message) begin
            state_d = S_PAD;
          end
        end
      end
      S_PAD: begin
        blk_d[cnt_q[5:2]][{~cnt_q[1:0], 3'b000} +: 8] = PAD_BYTE;
        // 56 bytes or more: length does not fit, it goes to an extra block
        if (cnt_q[5:3] == 3'b111) begin
          ret_d = RET_LEN;
        end else begin
          blk_d[14] = bit_len[63:32];
          blk_d[15] = bit_len[31:0];
          ret_d     = RET_OUT;
        end
        state_d = S_LOAD;
      end
      S_LEN: begin
        blk_d[14] = bit_len[63:32];
        blk_d[15] = bit_len[31:0];
        ret_d     = RET_OUT;
        state_d   = S_LOAD;
      end
      S_LOAD: begin
        sched_d = blk_q;
        vars_d  = chain_q;
        blk_d   = '0;
        rnd_d   = '0;
        state_d = S_ROUND;
      end
      S_ROUND: begin
        vars_d  = rnd_vars;
        sched_d = {w_new, sched_q[15:1]};
        rnd_d   = rnd_q + 6'd1;
        if (rnd_q == LAST_ROUND) begin
          state_d = S_ADD;
        end
      end
      S_ADD: begin
        for (int j = 0; j < 8; j++) begin
          chain_d[j] = chain_q[j] + vars_q[j];
        end
        unique case (ret_q)
          RET_IDLE: state_d = S_IDLE;
          RET_PAD:  state_d = S_PAD;
          RET_LEN:  state_d = S_LEN;
          RET_OUT: begin
            state_d = S_OUT;
            oidx_d  = '0;
          end
          default:  state_d = S_IDLE;
        endcase
      end
      S_OUT: begin
        if (out_acc) begin
          oidx_d = oidx_q + 3'd1;
          if (oidx_q == LAST_IDX) begin
            chain_d = INIT_H;
            cnt_d   = '0;
            total_d = '0;
            state_d = S_IDLE;
          end
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= RET_IDLE;
      cnt_q   <= '0;
      total_q <= '0;
      rnd_q   <= '0;
      oidx_q  <= '0;
      chain_q <= INIT_H;
      blk_q   <= '0;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      cnt_q   <= cnt_d;
      total_q <= total_d;
      rnd_q   <= rnd_d;
      oidx_q  <= oidx_d;
      chain_q <= chain_d;
      blk_q   <= blk_d;
    end
  end

  always_ff @(posedge clk_i) begin
    vars_q  <= vars_d;
    sched_q <= sched_d;
  end

`ifndef SYNTHESIS
  a_no_input_during_output: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid |-> !in_i.ready)
    else $error("input ready while digest pending");

  a_clean_after_digest: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_o.last_word) |=> (cnt_q == '0 && total_q == '0 && chain_q == INIT_H))
    else $error("state not restored after last digest word");

  a_rounds_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_ROUND && rnd_q == LAST_ROUND) |=> (state_q == S_ADD))
    else $error("compression did not finish after the last round");

  a_block_cleared: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOAD) |=> (blk_q == '0))
    else $error("block buffer not cleared at compression start");
`endif

endmodule
